/* sv/lst_pkg.sv */
// Shared types, constants and per-mode lookup functions for the subframe timestamp tracker.
`default_nettype none
package lst_pkg;

	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;
	localparam int ADJ_W  = 25;
	localparam int TS_W   = 64;

	// Register indexes (paddr[5:3])
	localparam logic [2:0] REG_BANDWIDTH_MODE   = 3'd0;
	localparam logic [2:0] REG_SUBFRAME_SAMPLES = 3'd1;
	localparam logic [2:0] REG_FRAME_SAMPLES    = 3'd2;
	localparam logic [2:0] REG_SYNC_POSITION    = 3'd3;
	localparam logic [2:0] REG_BASE_TIMESTAMP   = 3'd4;

	localparam logic [2:0]  RST_BANDWIDTH_MODE   = 3'd5;
	localparam logic [15:0] RST_SUBFRAME_SAMPLES = 16'd23040;
	localparam logic [19:0] RST_FRAME_SAMPLES    = 20'd230400;
	localparam logic [15:0] RST_SYNC_POSITION    = 16'd0;
	localparam logic [47:0] RST_BASE_TIMESTAMP   = 48'd0;

	localparam logic signed [15:0] FINE_INVALID = 16'sd9999;
	localparam logic signed [16:0] FINE_BIAS    = 17'sd32;
	localparam logic signed [15:0] SMALL_MIN    = -16'sd5;
	localparam logic signed [15:0] SMALL_MAX    = 16'sd5;

	typedef struct packed {
		logic [2:0]  bandwidth_mode;
		logic [15:0] subframe_samples;
		logic [19:0] frame_samples;
		logic [15:0] sync_position;
		logic [47:0] base_timestamp;
	} cfg_t;

	// Low fine limit per mode; unused modes behave as the widest one
	function automatic logic signed [16:0] lim_low(input logic [2:0] mode);
		logic signed [16:0] r;
		unique case (mode)
			3'd0: r = 17'sd22;
			3'd1: r = 17'sd22;
			3'd2: r = 17'sd26;
			3'd3: r = 17'sd29;
			3'd4: r = 17'sd30;
			default: r = 17'sd32;
		endcase
		return r;
	endfunction

	function automatic logic signed [16:0] lim_high(input logic [2:0] mode);
		logic signed [16:0] r;
		unique case (mode)
			3'd0: r = 17'sd16;
			3'd1: r = 17'sd14;
			3'd2: r = 17'sd13;
			3'd3: r = 17'sd9;
			3'd4: r = 17'sd9;
			default: r = 17'sd6;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] sync_scale(input logic [2:0] mode);
		logic [4:0] r;
		unique case (mode)
			3'd0: r = 5'd2;
			3'd1: r = 5'd4;
			3'd2: r = 5'd6;
			3'd3: r = 5'd12;
			3'd4: r = 5'd16;
			default: r = 5'd24;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* sv/lst_regs.sv */
// APB configuration register file of the subframe timestamp tracker.
`default_nettype none
module lst_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lst_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [lst_pkg::DATA_W-1:0]   pwdata,
	output logic      [lst_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output lst_pkg::cfg_t                     cfg
);

	lst_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr_en;

	assign idx    = paddr[5:3];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bandwidth_mode   <= lst_pkg::RST_BANDWIDTH_MODE;
			cfg_q.subframe_samples <= lst_pkg::RST_SUBFRAME_SAMPLES;
			cfg_q.frame_samples    <= lst_pkg::RST_FRAME_SAMPLES;
			cfg_q.sync_position    <= lst_pkg::RST_SYNC_POSITION;
			cfg_q.base_timestamp   <= lst_pkg::RST_BASE_TIMESTAMP;
		end else if (wr_en) begin
			unique case (idx)
				lst_pkg::REG_BANDWIDTH_MODE:   cfg_q.bandwidth_mode   <= pwdata[2:0];
				lst_pkg::REG_SUBFRAME_SAMPLES: cfg_q.subframe_samples <= pwdata[15:0];
				lst_pkg::REG_FRAME_SAMPLES:    cfg_q.frame_samples    <= pwdata[19:0];
				lst_pkg::REG_SYNC_POSITION:    cfg_q.sync_position    <= pwdata[15:0];
				lst_pkg::REG_BASE_TIMESTAMP:   cfg_q.base_timestamp   <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			lst_pkg::REG_BANDWIDTH_MODE:   prdata = {61'd0, cfg_q.bandwidth_mode};
			lst_pkg::REG_SUBFRAME_SAMPLES: prdata = {48'd0, cfg_q.subframe_samples};
			lst_pkg::REG_FRAME_SAMPLES:    prdata = {44'd0, cfg_q.frame_samples};
			lst_pkg::REG_SYNC_POSITION:    prdata = {48'd0, cfg_q.sync_position};
			lst_pkg::REG_BASE_TIMESTAMP:   prdata = {16'd0, cfg_q.base_timestamp};
			default:                       prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* sv/lst_adjust.sv */
// Timing adjustment from coarse/fine sync estimates and bandwidth mode.
`default_nettype none
module lst_adjust (
	input  wire logic [2:0]                      bandwidth_mode,
	input  wire logic [15:0]                     sync_position,
	input  wire logic signed [15:0]              coarse,
	input  wire logic signed [15:0]              fine,
	input  wire logic                            tracking,
	output logic signed [lst_pkg::ADJ_W-1:0]     adjust
);

	logic signed [16:0]              g;
	logic                            c_zero, c_one, c_small;
	logic signed [17:0]              op;
	logic signed [lst_pkg::ADJ_W-1:0] op_x, scale_x, prod;
	logic signed [15:0]              c_bias, half_c;

	assign c_zero  = (coarse == 16'sd0);
	assign c_one   = (coarse == 16'sd1);
	assign c_small = (coarse >= lst_pkg::SMALL_MIN) && (coarse <= lst_pkg::SMALL_MAX);
	assign g       = 17'(fine) + lst_pkg::FINE_BIAS;

	// Operand of the scaled rules: coarse itself when small, else offset by sync position
	assign op      = c_small ? 18'(coarse) : 18'(coarse) - $signed({2'b00, sync_position});
	assign op_x    = lst_pkg::ADJ_W'(op);
	assign scale_x = $signed({{(lst_pkg::ADJ_W-5){1'b0}}, lst_pkg::sync_scale(bandwidth_mode)});
	assign prod    = op_x * scale_x;

	// Halving truncated toward zero
	assign c_bias = coarse + $signed({15'd0, coarse[15]});
	assign half_c = c_bias >>> 1;

	always_comb begin
		priority if (fine == lst_pkg::FINE_INVALID) begin
			adjust = -25'sd1;
		end else if ((fine != 16'sd0) && c_zero) begin
			adjust = (g < lst_pkg::lim_low(bandwidth_mode)) ? -25'sd1 : 25'sd0;
		end else if ((fine != 16'sd0) && c_one) begin
			adjust = (g > lst_pkg::lim_high(bandwidth_mode)) ? 25'sd1 : 25'sd0;
		end else if (c_small && !tracking) begin
			adjust = lst_pkg::ADJ_W'(half_c);
		end else begin
			adjust = prod;
		end
	end

endmodule
`default_nettype wire

/* sv/lte_subframe_timestamp_tracker.sv */
// Top level of the LTE subframe timestamp tracker.
//
// Usage: each input transaction (in_valid/in_ready) requests one subframe and
// carries its index, coarse and fine sync estimates and the tracking flag. The
// block keeps a running frame-start offset; a frame length is added whenever
// the subframe index does not advance, then the timing adjustment is added.
// Each input transaction yields exactly one output transaction
// (out_valid/out_ready) with the subframe's first-sample timestamp and the
// adjustment applied.
// Pipeline: input register, adjust and offset update stage, timestamp sum
// into the output register.
// Throughput: one transaction per cycle while out_ready is high; the offset
// loop is a single register, so back-to-back items never wait on each other.
// Stall: when out_ready is low the output register holds and the pipeline
// fills; in_ready drops only once every stage holds a transaction.
// Reset (arst_n low): pipeline emptied, offset and last-subframe state cleared,
// registers back to their defaults. Configure over APB only while idle.
`default_nettype none
module lte_subframe_timestamp_tracker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// APB configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lst_pkg::ADDR_W-1:0]        paddr,
	input  wire logic [lst_pkg::DATA_W-1:0]        pwdata,
	output logic      [lst_pkg::DATA_W-1:0]        prdata,
	output logic                                   pready,
	// Request channel
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [3:0]                        subframe_index,
	input  wire logic signed [15:0]                coarse_estimate,
	input  wire logic signed [15:0]                fine_estimate,
	input  wire logic                              tracking,
	// Result channel
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [lst_pkg::TS_W-1:0]        sample_timestamp,
	output logic signed [lst_pkg::ADJ_W-1:0]       timing_adjust
);

	lst_pkg::cfg_t cfg;

	// Stage 1: registered request
	logic               v_s1;
	logic [3:0]         sf_s1;
	logic signed [15:0] coarse_s1, fine_s1;
	logic               trk_s1;

	// Stage 2: adjustment, updated offset, subframe product
	logic                              v_s2;
	logic [63:0]                       sum_s2;
	logic [20:0]                       prod_s2;
	logic signed [lst_pkg::ADJ_W-1:0]  adj_s2;

	// Running state
	logic [63:0] sum_q;
	logic [3:0]  last_sf_q;
	logic        last_valid_q;

	// Output register
	logic                              v_out_q;
	logic [63:0]                       ts_q;
	logic signed [lst_pkg::ADJ_W-1:0]  adj_out_q;

	logic                              adv_out, adv_s2, take_in;
	logic                              frame_adv;
	logic signed [lst_pkg::ADJ_W-1:0]  adj;
	logic [63:0]                       sum_next;
	logic [4:0]                        sf_plus1;

	lst_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lst_adjust u_adjust (
		.bandwidth_mode (cfg.bandwidth_mode),
		.sync_position  (cfg.sync_position),
		.coarse         (coarse_s1),
		.fine           (fine_s1),
		.tracking       (trk_s1),
		.adjust         (adj)
	);

	// Handshake chain: a stage advances when the next one is empty or draining
	assign adv_out  = v_s2 && (!v_out_q || out_ready);
	assign adv_s2   = v_s1 && (!v_s2 || adv_out);
	assign in_ready = !v_s1 || adv_s2;
	assign take_in  = in_valid && in_ready;

	// Frame length added when the subframe index does not move forward
	assign frame_adv = last_valid_q && (sf_s1 <= last_sf_q);
	assign sum_next  = sum_q + (frame_adv ? {44'd0, cfg.frame_samples} : 64'd0)
	                 + {{(64-lst_pkg::ADJ_W){adj[lst_pkg::ADJ_W-1]}}, adj};
	assign sf_plus1  = {1'b0, sf_s1} + 5'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_out_q      <= 1'b0;
			sum_q        <= '0;
			last_sf_q    <= '0;
			last_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (!v_s2 || adv_out) begin
				v_s2 <= adv_s2;
			end
			if (!v_out_q || out_ready) begin
				v_out_q <= v_s2;
			end
			if (adv_s2) begin
				sum_q        <= sum_next;
				last_sf_q    <= sf_s1;
				last_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		if (take_in) begin
			sf_s1     <= subframe_index;
			coarse_s1 <= coarse_estimate;
			fine_s1   <= fine_estimate;
			trk_s1    <= tracking;
		end
		if (adv_s2) begin
			sum_s2  <= sum_next;
			adj_s2  <= adj;
			// (index + 1) * subframe length covers both subframe terms
			prod_s2 <= sf_plus1 * cfg.subframe_samples;
		end
		if (adv_out) begin
			ts_q      <= {16'd0, cfg.base_timestamp} + {43'd0, prod_s2} + sum_s2;
			adj_out_q <= adj_s2;
		end
	end

	assign out_valid        = v_out_q;
	assign sample_timestamp = $signed(ts_q);
	assign timing_adjust    = adj_out_q;

endmodule
`default_nettype wire

/* dv/lte_subframe_timestamp_tracker_tb.sv */
// Self-checking testbench for the LTE subframe timestamp tracker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Run shape
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int DRAIN_CYCLES    = 8;    // idle slack after the last result is back
	localparam int WATCHDOG_LIMIT  = 2000; // cycles with work outstanding but no transaction

	localparam logic signed [15:0] FINE_INVALID_CODE = 16'sd9999;

	typedef struct {
		logic [3:0]         sf;
		logic signed [15:0] coarse;
		logic signed [15:0] fine;
		logic               trk;
	} subframe_req_t;

	typedef struct {
		logic [63:0] ts;
		logic [24:0] adj;
	} subframe_res_t;

	// Receiver stall styles, rotated in stretches of random length
	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_MOSTLY
	} ready_style_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// APB side
	logic                         psel    = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite  = 1'b0;
	logic [lst_pkg::ADDR_W-1:0]   paddr   = '0;
	logic [lst_pkg::DATA_W-1:0]   pwdata  = '0;
	logic [lst_pkg::DATA_W-1:0]   prdata;
	logic                         pready;

	// Request channel
	logic                in_valid        = 1'b0;
	logic                in_ready;
	logic [3:0]          subframe_index  = '0;
	logic signed [15:0]  coarse_estimate = '0;
	logic signed [15:0]  fine_estimate   = '0;
	logic                tracking        = 1'b0;

	// Result channel
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic signed [lst_pkg::TS_W-1:0]   sample_timestamp;
	logic signed [lst_pkg::ADJ_W-1:0]  timing_adjust;

	lte_subframe_timestamp_tracker dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.subframe_index   (subframe_index),
		.coarse_estimate  (coarse_estimate),
		.fine_estimate    (fine_estimate),
		.tracking         (tracking),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.sample_timestamp (sample_timestamp),
		.timing_adjust    (timing_adjust)
	);

	always #5 clk = ~clk;

	// Subframe requests not yet taken by the block, and results owed by it
	subframe_req_t pending_requests[$];
	subframe_res_t owed_results[$];

	int error_count = 0;

	// ------------------------------------------------------------------
	// Tracker model: register shadows plus the frame-start accumulator.
	// Shadows change only while the block is idle, so they are valid for
	// every transaction accepted after the write.
	// ------------------------------------------------------------------
	logic [2:0]  bw_mode_sh     = lst_pkg::RST_BANDWIDTH_MODE;
	logic [15:0] sf_len_sh      = lst_pkg::RST_SUBFRAME_SAMPLES;
	logic [19:0] frame_len_sh   = lst_pkg::RST_FRAME_SAMPLES;
	logic [15:0] sync_pos_sh    = lst_pkg::RST_SYNC_POSITION;
	logic [47:0] base_ts_sh     = lst_pkg::RST_BASE_TIMESTAMP;

	logic [63:0] frame_start_acc = '0;
	logic [3:0]  prev_sf         = '0;
	logic        sf_seen         = 1'b0;

	// Timing correction for one request, in signed samples
	function automatic int timing_correction(input logic signed [15:0] coarse,
			input logic signed [15:0] fine, input logic trk);
		int lo, hi, scale, c, f, g;
		// modes 6 and 7 are unused codes and fall back to 100 RB
		case (bw_mode_sh)
			3'd0: begin lo = 22; hi = 16; scale = 2;  end
			3'd1: begin lo = 22; hi = 14; scale = 4;  end
			3'd2: begin lo = 26; hi = 13; scale = 6;  end
			3'd3: begin lo = 29; hi = 9;  scale = 12; end
			3'd4: begin lo = 30; hi = 9;  scale = 16; end
			default: begin lo = 32; hi = 6; scale = 24; end
		endcase
		c = coarse;
		f = fine;
		if (fine == FINE_INVALID_CODE)
			return -1;
		if (f != 0 && (c == 0 || c == 1)) begin
			g = f + 32;
			if (c == 0)
				return (g < lo) ? -1 : 0;
			return (g > hi) ? 1 : 0;
		end
		if (c >= -5 && c <= 5)
			return trk ? c * scale : c / 2;
		return (c - int'(sync_pos_sh)) * scale;
	endfunction

	// Advance the accumulator by one request and return the timestamp it yields
	function automatic subframe_res_t track_subframe(input subframe_req_t r);
		subframe_res_t res;
		int adj;
		logic signed [63:0] adj_wide;
		if (sf_seen && r.sf <= prev_sf)
			frame_start_acc = frame_start_acc + 64'(frame_len_sh);
		adj = timing_correction(r.coarse, r.fine, r.trk);
		adj_wide = adj;
		frame_start_acc = frame_start_acc + adj_wide;
		res.ts = 64'(base_ts_sh) + 64'(sf_len_sh) + frame_start_acc
			+ 64'(r.sf) * 64'(sf_len_sh);
		res.adj = adj_wide[24:0];
		prev_sf = r.sf;
		sf_seen = 1'b1;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request driver: bursts of random length, random gaps in between.
	// A request once offered stays put until in_ready takes it.
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready)
				owed_results.push_back(track_subframe(pending_requests.pop_front()));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					in_valid        <= 1'b1;
					subframe_index  <= pending_requests[0].sf;
					coarse_estimate <= pending_requests[0].coarse;
					fine_estimate   <= pending_requests[0].fine;
					tracking        <= pending_requests[0].trk;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						// a quarter of the bursts run straight into the next one
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor and receiver. Besides the rotating stall styles it
	// holds out_ready low for a long stretch every few hundred results,
	// so the pipeline fills and in_ready has to drop.
	// ------------------------------------------------------------------
	int           results_seen   = 0;
	int           long_hold_at   = 60;
	int           hold_left      = 0;
	int           style_left     = 0;
	ready_style_t ready_style    = READY_ALWAYS;
	subframe_res_t due;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (owed_results.size() == 0) begin
					$display("%0t: unexpected result ts %h adj %h", $time,
						sample_timestamp, timing_adjust);
					error_count++;
				end else begin
					due = owed_results.pop_front();
					if (sample_timestamp !== due.ts) begin
						$display("%0t: sample_timestamp expected %h actual %h", $time,
							due.ts, sample_timestamp);
						error_count++;
					end
					if (timing_adjust !== due.adj) begin
						$display("%0t: timing_adjust expected %h actual %h", $time,
							due.adj, timing_adjust);
						error_count++;
					end
				end
			end

			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (results_seen >= long_hold_at) begin
				hold_left = $urandom_range(40, 120);
				long_hold_at = results_seen + $urandom_range(250, 500);
				out_ready <= 1'b0;
			end else begin
				if (style_left == 0) begin
					ready_style = ready_style_t'($urandom_range(0, 3));
					style_left = $urandom_range(16, 96);
				end
				style_left--;
				case (ready_style)
					READY_ALWAYS: out_ready <= 1'b1;
					READY_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
					READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:      out_ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: only counts while something is queued or owed.
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)
				|| (pending_requests.size() == 0 && owed_results.size() == 0)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d queued, %0d owed", $time,
					quiet_cycles, pending_requests.size(), owed_results.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// APB write: setup cycle, access cycle, then shadow update
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			lst_pkg::REG_BANDWIDTH_MODE:   bw_mode_sh   = value[2:0];
			lst_pkg::REG_SUBFRAME_SAMPLES: sf_len_sh    = value[15:0];
			lst_pkg::REG_FRAME_SAMPLES:    frame_len_sh = value[19:0];
			lst_pkg::REG_SYNC_POSITION:    sync_pos_sh  = value[15:0];
			lst_pkg::REG_BASE_TIMESTAMP:   base_ts_sh   = value[47:0];
			default: ;
		endcase
	endtask

	task automatic queue_request(input logic [3:0] sf, input logic signed [15:0] coarse,
			input logic signed [15:0] fine, input logic trk);
		subframe_req_t r;
		r.sf = sf;
		r.coarse = coarse;
		r.fine = fine;
		r.trk = trk;
		pending_requests.push_back(r);
	endtask

	// Block until every request is taken and every result is back
	task automatic wait_idle();
		while (pending_requests.size() != 0 || owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		logic [2:0]  mode;
		logic [15:0] ss;
		logic [19:0] fs;
		logic [15:0] sp;
		logic [47:0] base;
		logic [3:0]  sf;
		logic signed [15:0] coarse;
		logic signed [15:0] fine;
		int pick;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at reset defaults (100 RB: limits 32/6, scale 24, sync pos 0).
		// First request sees no previous subframe, so no frame is added.
		queue_request(4'd0,  0,      FINE_INVALID_CODE, 1'b0); // invalid fine
		queue_request(4'd1,  0,      -11,    1'b0); // coarse 0, below low limit
		queue_request(4'd2,  0,      0,      1'b1); // zero fine drops to small coarse
		queue_request(4'd3,  0,      -1,     1'b0); // just under low limit
		queue_request(4'd4,  0,      1,      1'b1); // just over it
		queue_request(4'd5,  1,      -26,    1'b0); // coarse 1, at high limit
		queue_request(4'd6,  1,      -25,    1'b1); // one above high limit
		queue_request(4'd7,  1,      32767,  1'b0);
		queue_request(4'd8,  0,      -32768, 1'b1);
		queue_request(4'd9,  5,      0,      1'b0); // small coarse halved
		queue_request(4'd9,  -5,     0,      1'b0); // repeat index: frame added
		queue_request(4'd0,  -5,     7,      1'b1); // wrap to 0: frame added
		queue_request(4'd15, 5,      100,    1'b1); // index past nine
		queue_request(4'd15, -3,     0,      1'b0); // odd negative halves toward zero
		queue_request(4'd3,  6,      0,      1'b0); // large coarse
		queue_request(4'd4,  -6,     0,      1'b1);
		queue_request(4'd5,  32767,  0,      1'b1);
		queue_request(4'd6,  -32768, 0,      1'b1);
		queue_request(4'd7,  32767,  -32768, 1'b0);
		queue_request(4'd8,  5,      FINE_INVALID_CODE, 1'b1);
		queue_request(4'd10, -1,     32767,  1'b0);
		queue_request(4'd2,  2,      -1,     1'b1);
		wait_idle();

		sf = 4'd2;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin mode = 3'd0; ss = 16'd1; fs = 20'd1; sp = 16'd0; base = '0; end
				1: begin
					mode = 3'd7; ss = 16'hFFFF; fs = 20'hFFFFF; sp = 16'hFFFF;
					base = 48'hFFFF_FFFF_FFFF;
				end
				// zero lengths are taken as they are
				2: begin
					mode = 3'd6; ss = 16'd0; fs = 20'd0; sp = 16'd1;
					base = 48'({$urandom, $urandom});
				end
				default: begin
					mode = 3'((ph - 1) % 6);
					ss = 16'($urandom_range(1, 65535));
					fs = 20'($urandom_range(1, 655350));
					sp = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65535))
						: 16'($urandom_range(0, 40));
					base = 48'({$urandom, $urandom});
				end
			endcase
			write_reg(lst_pkg::REG_BANDWIDTH_MODE,   64'(mode));
			write_reg(lst_pkg::REG_SUBFRAME_SAMPLES, 64'(ss));
			write_reg(lst_pkg::REG_FRAME_SAMPLES,    64'(fs));
			write_reg(lst_pkg::REG_SYNC_POSITION,    64'(sp));
			write_reg(lst_pkg::REG_BASE_TIMESTAMP,   64'(base));

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Mostly a running subframe count, with repeats, jumps and strays
				pick = $urandom_range(0, 31);
				if (pick == 0)
					sf = 4'($urandom_range(0, 15));
				else if (pick < 3)
					sf = sf;
				else if (pick < 5)
					sf = 4'($urandom_range(0, 9));
				else
					sf = (sf >= 4'd9) ? 4'd0 : sf + 4'd1;

				case ($urandom_range(0, 7))
					0, 1: coarse = 16'($urandom_range(0, 1));
					2, 3: coarse = 16'(int'($urandom_range(0, 10)) - 5);
					4:    coarse = 16'(int'(sync_pos_sh) + int'($urandom_range(0, 20)) - 10);
					default: coarse = 16'($urandom);
				endcase

				case ($urandom_range(0, 7))
					0: fine = FINE_INVALID_CODE;
					1: fine = 16'sd0;
					// fine + 32 lands around both limits
					2, 3: fine = 16'(int'($urandom_range(0, 60)) - 50);
					default: fine = 16'($urandom);
				endcase

				queue_request(sf, coarse, fine, 1'($urandom_range(0, 1)));
			end
			wait_idle();
		end

		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* files.f */
sv/lst_pkg.sv
sv/lst_regs.sv
sv/lst_adjust.sv
sv/lte_subframe_timestamp_tracker.sv
dv/lte_subframe_timestamp_tracker_tb.sv
